### design/itw_pkg.sv
// Shared types, codes and defaults for the idle connection timing wheel.
`default_nettype none

package itw_pkg;

    // Field widths of the stream beats.
    localparam int REQ_W   = 2;
    localparam int ID_W    = 6;
    localparam int CNT_W   = 3;
    localparam int TDATA_W = 8;

    // Default sizes handed to the top level.
    localparam int WHEEL_SLOTS_DEF = 8;
    localparam int NUM_CONN_DEF    = 64;

    // Request codes carried in tuser of the input beat.
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CONNECT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MESSAGE = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic tick;
        logic shift;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### design/idle_connection_timing_wheel_core.sv
// Top level of the idle connection timing wheel: slot cell chain and sequencer.
//
//   Channel  Direction  Ports                        Content
//   s        in         i_s_tvalid/o_s_tready        tuser req_type, tdata slot id
//   m        out        o_m_tvalid/i_m_tready        tuser expired, tdata id, tlast
//
// A connect or message beat is applied directly to its slot. A tick beat holds the
// input off until the result has been emitted: every cell ages at once, then in
// NUM_CONN steps the expiry bits shift down the cell chain one slot per cycle
// to the head, and last the final result is emitted. The chain moves only while
// the output register can take a beat; otherwise it stalls.
// Reset is synchronous and clears every slot in the same cycle; no sweep is needed.
`default_nettype none

module idle_connection_timing_wheel_core #(
    parameter int WHEEL_SLOTS = itw_pkg::WHEEL_SLOTS_DEF,
    parameter int NUM_CONN    = itw_pkg::NUM_CONN_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_s_tvalid,
    output logic                        o_s_tready,
    // [1:0] req_type
    input  wire  [itw_pkg::REQ_W-1:0]   i_s_tuser,
    // [5:0] conn_id, [7:6] zero
    input  wire  [itw_pkg::TDATA_W-1:0] i_s_tdata,
    output logic                        o_m_tvalid,
    input  wire                         i_m_tready,
    // [0] expired
    output logic                        o_m_tuser,
    // [5:0] close_id, [7:6] zero
    output logic [itw_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                        o_m_tlast
);

    logic [itw_pkg::REQ_W-1:0] w_kind;
    logic [itw_pkg::ID_W-1:0]  w_id;
    logic                      w_accept;
    logic                      w_id_ok;
    logic                      w_start;
    logic                      w_conn;
    logic                      w_msg;
    itw_pkg::t_cell_ctrl       w_ctrl;
    logic [NUM_CONN:0]         w_pend;

    // Request decode.
    assign w_kind   = i_s_tuser;
    assign w_id     = i_s_tdata[itw_pkg::ID_W-1:0];
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_id_ok  = ({1'b0, w_id} < (itw_pkg::ID_W+1)'(NUM_CONN));
    assign w_start  = w_accept && (w_kind == itw_pkg::REQ_TICK);
    assign w_conn   = w_accept && w_id_ok && (w_kind == itw_pkg::REQ_CONNECT);
    assign w_msg    = w_accept && w_id_ok && (w_kind == itw_pkg::REQ_MESSAGE);

    // The cell past the end feeds zeros into the chain.
    assign w_pend[NUM_CONN] = 1'b0;

    // Row of slot cells; expiry bits move toward slot zero.
    for (genvar g = 0; g < NUM_CONN; g++) begin : g_cell
        itw_cell #(
            .WHEEL_SLOTS(WHEEL_SLOTS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl),
            .i_conn (w_conn && (w_id == itw_pkg::ID_W'(g))),
            .i_msg  (w_msg && (w_id == itw_pkg::ID_W'(g))),
            .i_pend (w_pend[g+1]),
            .o_pend (w_pend[g])
        );
    end

    itw_ctrl #(
        .NUM_CONN(NUM_CONN)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_head_pend(w_pend[0]),
        .o_ready    (o_s_tready),
        .o_ctrl     (w_ctrl),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

### design/itw_cell.sv
// One connection slot: active flag, idle count and a shifting expiry bit.
`default_nettype none

module itw_cell #(
    parameter int WHEEL_SLOTS = itw_pkg::WHEEL_SLOTS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  itw_pkg::t_cell_ctrl i_ctrl,
    input  wire                 i_conn,
    input  wire                 i_msg,
    input  wire                 i_pend,
    output logic                o_pend
);

    logic                      r_active, n_active;
    logic [itw_pkg::CNT_W-1:0] r_count, n_count;
    logic                      r_pend, n_pend;
    logic                      w_expire;

    // The slot expires when one more tick reaches the wheel length.
    assign w_expire = r_active &&
        (({1'b0, r_count} + (itw_pkg::CNT_W+1)'(1)) >= (itw_pkg::CNT_W+1)'(WHEEL_SLOTS));

    // Slot state update.
    always_comb begin
        n_active = r_active;
        n_count  = r_count;
        n_pend   = r_pend;
        if (i_ctrl.tick) begin
            n_pend = w_expire;
            if (w_expire) begin
                n_active = 1'b0;
                n_count  = '0;
            end else if (r_active) begin
                n_count = r_count + itw_pkg::CNT_W'(1);
            end
        end else begin
            if (i_ctrl.shift) begin
                n_pend = i_pend;
            end
            if (i_conn) begin
                n_active = 1'b1;
                n_count  = '0;
            end else if (i_msg && r_active) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_count  <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_count  <= n_count;
            r_pend   <= n_pend;
        end
    end

    assign o_pend = r_pend;

endmodule

`default_nettype wire

### design/itw_ctrl.sv
// Sequencer: walks the expiry chain after a tick and drives the result stream.
`default_nettype none

module itw_ctrl #(
    parameter int NUM_CONN = itw_pkg::NUM_CONN_DEF
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire                       i_head_pend,
    output logic                      o_ready,
    output itw_pkg::t_cell_ctrl       o_ctrl,
    output logic                      o_m_tvalid,
    input  wire                       i_m_tready,
    output logic                      o_m_tuser,
    output logic [itw_pkg::TDATA_W-1:0] o_m_tdata,
    output logic                      o_m_tlast
);

    itw_pkg::t_state          r_state, n_state;
    logic [itw_pkg::ID_W-1:0] r_cnt, n_cnt;
    logic                     r_hold_v, n_hold_v;
    logic [itw_pkg::ID_W-1:0] r_hold_id, n_hold_id;
    logic                     r_out_v, n_out_v;
    logic                     r_out_exp, n_out_exp;
    logic [itw_pkg::ID_W-1:0] r_out_id, n_out_id;
    logic                     r_out_last, n_out_last;
    logic                     w_can_push;
    logic                     w_scan_end;

    assign w_can_push = !r_out_v || i_m_tready;
    assign w_scan_end = (r_cnt == itw_pkg::ID_W'(NUM_CONN - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itw_pkg::S_IDLE: begin
                if (i_start) n_state = itw_pkg::S_SCAN;
            end
            itw_pkg::S_SCAN: begin
                if (w_can_push && w_scan_end) n_state = itw_pkg::S_FINISH;
            end
            itw_pkg::S_FINISH: begin
                if (w_can_push) n_state = itw_pkg::S_IDLE;
            end
            default: n_state = itw_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath. A found close is held back one step so that the
    // final one can be flagged last.
    always_comb begin
        o_ready      = (r_state == itw_pkg::S_IDLE);
        o_ctrl.tick  = 1'b0;
        o_ctrl.shift = 1'b0;
        n_cnt        = r_cnt;
        n_hold_v     = r_hold_v;
        n_hold_id    = r_hold_id;
        n_out_v      = r_out_v && !i_m_tready;
        n_out_exp    = r_out_exp;
        n_out_id     = r_out_id;
        n_out_last   = r_out_last;
        unique case (r_state)
            itw_pkg::S_IDLE: begin
                if (i_start) begin
                    o_ctrl.tick = 1'b1;
                    n_cnt       = '0;
                    n_hold_v    = 1'b0;
                end
            end
            itw_pkg::S_SCAN: begin
                if (w_can_push) begin
                    o_ctrl.shift = 1'b1;
                    n_cnt        = r_cnt + itw_pkg::ID_W'(1);
                    if (i_head_pend) begin
                        if (r_hold_v) begin
                            n_out_v    = 1'b1;
                            n_out_exp  = 1'b1;
                            n_out_id   = r_hold_id;
                            n_out_last = 1'b0;
                        end
                        n_hold_v  = 1'b1;
                        n_hold_id = r_cnt;
                    end
                end
            end
            itw_pkg::S_FINISH: begin
                if (w_can_push) begin
                    n_out_v    = 1'b1;
                    n_out_exp  = r_hold_v;
                    n_out_id   = r_hold_v ? r_hold_id : '0;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                end
            end
            default: begin
                n_hold_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= itw_pkg::S_IDLE;
            r_cnt    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hold_id  <= n_hold_id;
        r_out_exp  <= n_out_exp;
        r_out_id   <= n_out_id;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_out_exp;
    assign o_m_tdata  = {{(itw_pkg::TDATA_W - itw_pkg::ID_W){1'b0}}, r_out_id};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

### bench/idle_connection_timing_wheel_core_test.sv
// Self-checking testbench for the idle connection timing wheel core.

module idle_connection_timing_wheel_core_test;

    localparam int                        SLOTS      = itw_pkg::WHEEL_SLOTS_DEF;
    localparam int                        CONNS      = itw_pkg::NUM_CONN_DEF;
    localparam logic [itw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int                        RAND_ITEMS = 180;
    localparam int                        LONG_HOLD  = 300;

    // One expected close beat.
    typedef struct packed {
        logic                     expired;
        logic [itw_pkg::ID_W-1:0] close_id;
        logic                     last;
    } t_close_beat;

    // Tracks the slot table and the close beats that the accepted requests must cause.
    class t_close_scoreboard;
        bit                        slot_on  [CONNS];
        bit [itw_pkg::CNT_W-1:0]   idle_age [CONNS];
        t_close_beat               pending  [$];
        int                        errors;

        function new();
            for (int i = 0; i < CONNS; i++) begin
                slot_on[i]  = 1'b0;
                idle_age[i] = '0;
            end
            errors = 0;
        endfunction

        // Apply one accepted request to the table and queue the closes it causes.
        function void note_request(logic [itw_pkg::REQ_W-1:0] kind,
                                   logic [itw_pkg::ID_W-1:0] id);
            t_close_beat beat;
            int          closes;
            closes = 0;
            if (kind == itw_pkg::REQ_TICK) begin
                for (int i = 0; i < CONNS; i++) begin
                    if (slot_on[i]) begin
                        if (int'(idle_age[i]) + 1 >= SLOTS) begin
                            slot_on[i]  = 1'b0;
                            idle_age[i] = '0;
                            beat.expired  = 1'b1;
                            beat.close_id = itw_pkg::ID_W'(i);
                            beat.last     = 1'b0;
                            pending = {pending, beat};
                            closes++;
                        end else begin
                            idle_age[i] = idle_age[i] + 1'b1;
                        end
                    end
                end
                // A quiet tick still reports once, with nothing expired.
                if (closes == 0) begin
                    beat = '{expired: 1'b0, close_id: '0, last: 1'b1};
                    pending = {pending, beat};
                end else begin
                    pending[pending.size() - 1].last = 1'b1;
                end
            end else if (int'(id) < CONNS) begin
                if (kind == itw_pkg::REQ_CONNECT) begin
                    slot_on[id]  = 1'b1;
                    idle_age[id] = '0;
                end else if (kind == itw_pkg::REQ_MESSAGE && slot_on[id]) begin
                    idle_age[id] = '0;
                end
            end
        endfunction

        // Compare one accepted output beat against the oldest expectation.
        function void check_close(logic tuser, logic [itw_pkg::TDATA_W-1:0] tdata,
                                  logic tlast);
            t_close_beat want;
            if (pending.size() == 0) begin
                $error("close beat with nothing expected: tuser=%b tdata=%h tlast=%b",
                       tuser, tdata, tlast);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (tuser !== want.expired) begin
                $error("expired: expected %b, got %b", want.expired, tuser);
                errors++;
            end
            if (tdata[itw_pkg::ID_W-1:0] !== want.close_id) begin
                $error("close_id: expected %0d, got %0d", want.close_id,
                       tdata[itw_pkg::ID_W-1:0]);
                errors++;
            end
            if (tlast !== want.last) begin
                $error("last: expected %b, got %b", want.last, tlast);
                errors++;
            end
            if (tdata[itw_pkg::TDATA_W-1:itw_pkg::ID_W] !== '0) begin
                $error("pad: expected 0, got %b", tdata[itw_pkg::TDATA_W-1:itw_pkg::ID_W]);
                errors++;
            end
        endfunction
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [itw_pkg::REQ_W-1:0]   i_s_tuser;
    logic [itw_pkg::TDATA_W-1:0] i_s_tdata;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic                        o_m_tuser;
    logic [itw_pkg::TDATA_W-1:0] o_m_tdata;
    logic                        o_m_tlast;

    t_close_scoreboard sb;
    bit                idle_on;
    bit                hold_req;

    idle_connection_timing_wheel_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // Clock with a period of two time units.
    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Offer one request beat and hold it until the block takes it.
    task automatic send_req(logic [itw_pkg::REQ_W-1:0] kind, logic [itw_pkg::ID_W-1:0] id);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {{(itw_pkg::TDATA_W - itw_pkg::ID_W){1'b0}}, id};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_request(kind, id);
    endtask

    // Now and then drop valid for a random burst of cycles.
    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Stop sending until every expected close beat has come back.
    task automatic drain_closes();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Extremes of the slot index, every request code and the special cases.
    task automatic run_directed();
        send_req(itw_pkg::REQ_TICK, 6'd0);       // nothing active yet
        send_req(itw_pkg::REQ_CONNECT, 6'd0);
        send_req(itw_pkg::REQ_CONNECT, 6'd63);
        send_req(itw_pkg::REQ_MESSAGE, 6'd5);    // inactive slot, ignored
        send_req(itw_pkg::REQ_CONNECT, 6'd42);
        send_req(itw_pkg::REQ_CONNECT, 6'd21);
        send_req(itw_pkg::REQ_TICK, 6'd63);      // slot field ignored on ticks
        send_req(itw_pkg::REQ_CONNECT, 6'd42);   // reconnect clears the age
        send_req(itw_pkg::REQ_MESSAGE, 6'd63);   // refresh of an active slot
        send_req(REQ_UNUSED, 6'd63);
        send_req(REQ_UNUSED, 6'd0);
        for (int t = 0; t < SLOTS + 1; t++) begin
            maybe_gap();
            send_req(itw_pkg::REQ_TICK, itw_pkg::ID_W'($urandom_range(0, 63)));
        end
        send_req(itw_pkg::REQ_TICK, 6'd0);       // everything has closed again
        drain_closes();
    endtask

    // Mostly connects, messages (often to recently connected slots) and ticks, with some noise.
    task automatic run_random();
        logic [itw_pkg::REQ_W-1:0] kind;
        logic [itw_pkg::ID_W-1:0]  id;
        logic [itw_pkg::ID_W-1:0]  recent [$];
        int                        pick;
        int                        counted;
        counted = 0;
        while (counted < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            id   = itw_pkg::ID_W'($urandom_range(0, 63));
            if (pick < 38) begin
                kind = itw_pkg::REQ_TICK;
            end else if (pick < 65) begin
                kind = itw_pkg::REQ_CONNECT;
                recent = {recent, id};
                if (recent.size() > 8) void'(recent.pop_front());
            end else if (pick < 95) begin
                kind = itw_pkg::REQ_MESSAGE;
                if (recent.size() > 0 && $urandom_range(0, 1) == 1)
                    id = recent[$urandom_range(0, recent.size() - 1)];
            end else begin
                kind = REQ_UNUSED;
            end
            if (kind != REQ_UNUSED) counted++;

            // Long receiver hold-off while the requests keep coming.
            if (counted == 60 && kind != REQ_UNUSED) hold_req <= 1'b1;
            if (counted == 120 && kind != REQ_UNUSED) drain_closes();
            if (counted == RAND_ITEMS - 30) idle_on = 1'b0;

            maybe_gap();
            send_req(kind, id);
        end
    endtask

    // Request side: reset, directed part, random part, drain, verdict.
    initial begin
        sb         = new();
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tuser  <= '0;
        i_s_tdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random();

        drain_closes();
        repeat (CONNS + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Close side: check accepted beats and pace tready.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) sb.check_close(o_m_tuser, o_m_tdata, o_m_tlast);
            if (hold_req) begin
                hold_req  <= 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
